// File: design/rne_pkg.sv
package rne_pkg;

   // Field widths and the range of values that have a numeral.
   localparam int VALUE_W             = 12;
   localparam int CHAR_W              = 7;
   localparam int NUM_SYMBOLS         = 13;
   localparam int SYM_W               = 4;
   localparam int MAX_VALUE           = 3999;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [CHAR_W-1:0] CHAR_NONE = 7'd0;
   localparam logic [CHAR_W-1:0] CHAR_M    = 7'h4D;
   localparam logic [CHAR_W-1:0] CHAR_D    = 7'h44;
   localparam logic [CHAR_W-1:0] CHAR_C    = 7'h43;
   localparam logic [CHAR_W-1:0] CHAR_L    = 7'h4C;
   localparam logic [CHAR_W-1:0] CHAR_X    = 7'h58;
   localparam logic [CHAR_W-1:0] CHAR_V    = 7'h56;
   localparam logic [CHAR_W-1:0] CHAR_I    = 7'h49;

   // One queued request, already classified by the front end.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               invalid;
   } entry_type;

   // Value of each symbol, largest first.
   function automatic logic [VALUE_W-1:0] sym_val(input logic [SYM_W-1:0] idx);
      logic [VALUE_W-1:0] v;
      case (idx)
         4'd0:    v = 12'd1000;
         4'd1:    v = 12'd900;
         4'd2:    v = 12'd500;
         4'd3:    v = 12'd400;
         4'd4:    v = 12'd100;
         4'd5:    v = 12'd90;
         4'd6:    v = 12'd50;
         4'd7:    v = 12'd40;
         4'd8:    v = 12'd10;
         4'd9:    v = 12'd9;
         4'd10:   v = 12'd5;
         4'd11:   v = 12'd4;
         default: v = 12'd1;
      endcase
      return v;
   endfunction

   // First character of each symbol.
   function automatic logic [CHAR_W-1:0] sym_first(input logic [SYM_W-1:0] idx);
      logic [CHAR_W-1:0] c;
      case (idx)
         4'd0:    c = CHAR_M;
         4'd1:    c = CHAR_C;
         4'd2:    c = CHAR_D;
         4'd3:    c = CHAR_C;
         4'd4:    c = CHAR_C;
         4'd5:    c = CHAR_X;
         4'd6:    c = CHAR_L;
         4'd7:    c = CHAR_X;
         4'd8:    c = CHAR_X;
         4'd9:    c = CHAR_I;
         4'd10:   c = CHAR_V;
         default: c = CHAR_I;
      endcase
      return c;
   endfunction

   // Second character of the subtractive symbols; none for the others.
   function automatic logic [CHAR_W-1:0] sym_second(input logic [SYM_W-1:0] idx);
      logic [CHAR_W-1:0] c;
      case (idx)
         4'd1:    c = CHAR_M;
         4'd3:    c = CHAR_D;
         4'd5:    c = CHAR_C;
         4'd7:    c = CHAR_L;
         4'd9:    c = CHAR_X;
         4'd11:   c = CHAR_V;
         default: c = CHAR_NONE;
      endcase
      return c;
   endfunction

endpackage

// File: design/rne_front.sv
module rne_front
   import rne_pkg::*;
(
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               q_full,
   output logic               q_push,
   output entry_type          q_push_entry
);

   // A request is taken whenever the queue has room.
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   // Classify the request: zero and values past the top of the range have no numeral.
   always_comb begin
      q_push_entry.value   = req_value;
      q_push_entry.invalid = (req_value == '0) || (req_value > VALUE_W'(MAX_VALUE));
   end

endmodule

// File: design/rne_queue.sv
module rne_queue
   import rne_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      head_valid,
   output entry_type head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates, with explicit wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots need no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue written while full");
   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("queue read while empty");
   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_CNT)
      else $error("queue fill count beyond depth");

endmodule

// File: design/rne_back.sv
module rne_back
   import rne_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  entry_type         head_entry,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAR_W-1:0] rsp_symbol_char,
   output logic              rsp_is_last,
   output logic              rsp_invalid
);

   logic [VALUE_W-1:0] rem_ff, rem_in;
   logic [CHAR_W-1:0]  pend_ff, pend_in;
   logic               busy_ff, busy_in;
   logic               out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]  out_char_ff, out_char_in;
   logic               out_last_ff, out_last_in;
   logic               out_inv_ff, out_inv_in;

   logic               advance;
   logic [VALUE_W-1:0] src;
   logic [SYM_W-1:0]   sym_idx;
   logic [VALUE_W-1:0] next_rem;
   logic [CHAR_W-1:0]  second;

   // The output register may be refilled when empty or when its result is taken.
   assign advance = !out_valid_ff || rsp_ready;
   assign q_pop   = advance && !busy_ff && head_valid;

   // The numeral in progress, or else the request at the head of the queue.
   assign src = busy_ff ? rem_ff : head_entry.value;

   // Largest symbol that fits: the compares are independent, the lowest index wins.
   always_comb begin
      sym_idx = SYM_W'(NUM_SYMBOLS - 1);
      for (int k = NUM_SYMBOLS - 1; k >= 0; k--) begin
         if (src >= sym_val(SYM_W'(k))) begin
            sym_idx = SYM_W'(k);
         end
      end
   end

   assign next_rem = src - sym_val(sym_idx);
   assign second   = sym_second(sym_idx);

   // Sequencer: one character per cycle unless stalled, a subtractive pair in order.
   always_comb begin
      rem_in       = rem_ff;
      pend_in      = pend_ff;
      busy_in      = busy_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_inv_in   = out_inv_ff;
      if (advance) begin
         if (busy_ff && (pend_ff != CHAR_NONE)) begin
            out_valid_in = 1'b1;
            out_char_in  = pend_ff;
            out_last_in  = (rem_ff == '0);
            out_inv_in   = 1'b0;
            pend_in      = CHAR_NONE;
            busy_in      = (rem_ff != '0);
         end else if (!busy_ff && head_valid && head_entry.invalid) begin
            out_valid_in = 1'b1;
            out_char_in  = CHAR_NONE;
            out_last_in  = 1'b1;
            out_inv_in   = 1'b1;
         end else if (busy_ff || head_valid) begin
            out_valid_in = 1'b1;
            out_char_in  = sym_first(sym_idx);
            out_inv_in   = 1'b0;
            rem_in       = next_rem;
            pend_in      = second;
            if (second != CHAR_NONE) begin
               out_last_in = 1'b0;
               busy_in     = 1'b1;
            end else begin
               out_last_in = (next_rem == '0);
               busy_in     = (next_rem != '0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         pend_ff      <= CHAR_NONE;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         pend_ff      <= pend_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload register needs no reset.
   always_ff @(posedge clock) begin
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_inv_ff  <= out_inv_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_symbol_char = out_char_ff;
   assign rsp_is_last     = out_last_ff;
   assign rsp_invalid     = out_inv_ff;

   assert property (@(posedge clock) disable iff (reset)
         !busy_ff |-> (rem_ff == '0) && (pend_ff == CHAR_NONE))
      else $error("idle sequencer holds leftover work");
   assert property (@(posedge clock) disable iff (reset)
         rsp_valid && rsp_invalid |-> rsp_is_last && (rsp_symbol_char == CHAR_NONE))
      else $error("error result malformed");
   assert property (@(posedge clock) disable iff (reset)
         rsp_valid && !rsp_invalid |-> (rsp_symbol_char != CHAR_NONE))
      else $error("numeral character missing");
   assert property (@(posedge clock) disable iff (reset)
         busy_ff && (pend_ff == CHAR_NONE) |-> (rem_ff != '0))
      else $error("sequencer busy with nothing left to emit");

endmodule

// File: design/roman_numeral_encoder.sv
// The first character of a request is registered in the queue and then in the sequencer's output register.
// The sequencer sends one character per cycle while rsp_ready does not stall it; a numeral has
// 1 to 15 characters (15 for 3888); an out-of-range value gives one error result.
// A queue between classifier and sequencer lets new requests enter while a numeral is sent.
// Reset (synchronous, active high) empties the queue, clears the sequencer and drops rsp_valid.
module roman_numeral_encoder
   import rne_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CHAR_W-1:0]  rsp_symbol_char,
   output logic               rsp_is_last,
   output logic               rsp_invalid
);

   logic      q_full;
   logic      q_push;
   entry_type q_push_entry;
   logic      q_pop;
   logic      head_valid;
   entry_type head_entry;

   // Front end: accepts and classifies requests.
   rne_front u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_push_entry (q_push_entry)
   );

   // Short queue decoupling the two halves.
   rne_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Back end: emits the numeral one character at a time.
   rne_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_entry      (head_entry),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_symbol_char (rsp_symbol_char),
      .rsp_is_last     (rsp_is_last),
      .rsp_invalid     (rsp_invalid)
   );

endmodule
